>>> design/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/lss_pkg.sv
// Shared types and codes for the lottery slot scheduler.
// Depends on nothing; used by all scheduler modules.
package lss_pkg;

    localparam int RAND_W     = 32;
    localparam int WEIGHT_W   = 8;
    localparam int WEIGHT_MAX = 255;
    localparam int OUT_W      = 12;
    localparam logic [OUT_W-1:0] OUT_MAX = 12'hFFF;

    // Operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STATE = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_RUNNING = 2'd1;
    localparam logic [1:0] STATUS_BAD_STATE  = 2'd2;
    localparam logic [1:0] STATUS_NO_TICKETS = 2'd3;

    // Run states
    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_PAUSED  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // Priorities
    localparam logic [1:0] PRIO_LOW    = 2'd0;
    localparam logic [1:0] PRIO_MEDIUM = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_WEIGHT_LOW    = 2'd0;
    localparam logic [1:0] CFG_WEIGHT_MEDIUM = 2'd1;
    localparam logic [1:0] CFG_WEIGHT_HIGH   = 2'd2;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SUM      = 6'b000010,
        S_MOD      = 6'b000100,
        S_SEL      = 6'b001000,
        S_UPD_PREV = 6'b010000,
        S_UPD_PICK = 6'b100000
    } fsm_t;

    // Slot table write command
    typedef struct packed {
        logic       prio_en;
        logic       state_en;
        logic [1:0] prio;
        logic [1:0] state;
    } mem_wr_t;

endpackage

>>> design/lss_slot_mem.sv
// Slot table: priority and run state per slot, one write and one read port.
// Depends on lss_pkg for the write command type.
module lss_slot_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                 clk,
    input  lss_pkg::mem_wr_t     wr,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [1:0]           rd_prio,
    output logic [1:0]           rd_state
);

    logic [1:0] prio_mem  [DEPTH];
    logic [1:0] state_mem [DEPTH];

    // Write either field at the write address
    always_ff @(posedge clk)
    begin
        if (wr.prio_en)
        begin
            prio_mem[wr_addr] <= wr.prio;
        end
        if (wr.state_en)
        begin
            state_mem[wr_addr] <= wr.state;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_prio  <= prio_mem[rd_addr];
        rd_state <= state_mem[rd_addr];
    end

endmodule

>>> design/lss_mod_unit.sv
// Iterative restoring modulo: 32-bit dividend by a narrow divisor, one bit a cycle.
// Depends on lss_pkg for the dividend width.
module lss_mod_unit #(
    parameter int DIV_W = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lss_pkg::RAND_W-1:0] dividend,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       done,
    output logic [DIV_W-1:0]           remainder
);

    localparam int CNT_W = $clog2(lss_pkg::RAND_W + 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [lss_pkg::RAND_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]           div_reg, div_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [DIV_W:0]             trial;

    assign trial = {rem_reg, dvd_reg[lss_pkg::RAND_W-1]};

    // Shift in one dividend bit, subtract when it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[lss_pkg::RAND_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(lss_pkg::RAND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> design/lottery_slot_scheduler_core.sv
// Lottery slot scheduler top level: sequencer, slot state, weights, outputs.
// Depends on lss_pkg, lss_slot_mem, lss_mod_unit and assert_macros.svh.
//
// Usage: raise start with the item fields while busy is low; the item is
// taken at that edge. Each item gives exactly one result, shown for one
// cycle with done high; the receiver cannot stall it.
// Load, set-state and unknown operations never raise busy: done follows the
// accepting edge.
// A draw walks the slot table through its single read port to sum the
// tickets, runs a 32-step bit-serial modulo, then walks again until the
// winner is found; with no tickets it ends after the first walk. Busy stays
// high meanwhile. The walks share one accumulator adder.
// Configuration: cfg_valid with cfg_index and cfg_data, always ready; write
// only while busy is low and no result is pending.
// Reset: weights return to 1, 2 and 4, all slots are absent, no slot runs.
`include "assert_macros.svh"

module lottery_slot_scheduler_core #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [3:0]  slot,
    input  logic        present,
    input  logic [1:0]  priority_req,
    input  logic [1:0]  run_state,
    input  logic [31:0] random_value,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  chosen_slot,
    output logic [11:0] ticket_total,
    output logic [11:0] draw_ticket,
    output logic [1:0]  applied_state,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int TOT_W  = $clog2(NUM_SLOTS * lss_pkg::WEIGHT_MAX + 1);
    localparam int ACC_W  = TOT_W + 1;

    lss_pkg::fsm_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rv_reg, rv_next;
    logic [SLOT_W-1:0] ridx_reg, ridx_next;
    logic              rpres_reg, rpres_next;
    logic [TOT_W-1:0]  acc_reg, acc_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [TOT_W-1:0]  win_reg, win_next;
    logic [SLOT_W-1:0] pick_reg, pick_next;
    logic [lss_pkg::RAND_W-1:0] rnd_reg, rnd_next;
    logic              run_valid_reg, run_valid_next;
    logic [SLOT_W-1:0] run_slot_reg, run_slot_next;
    logic [NUM_SLOTS-1:0] present_reg, present_next;
    logic [7:0]        wl_reg, wm_reg, wh_reg;

    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [3:0]        chosen_reg, chosen_next;
    logic [11:0]       total_out_reg, total_out_next;
    logic [11:0]       win_out_reg, win_out_next;
    logic [1:0]        applied_reg, applied_next;

    lss_pkg::mem_wr_t  mem_wr;
    logic [SLOT_W-1:0] mem_wr_addr;
    logic [SLOT_W-1:0] mem_rd_addr;
    logic [1:0]        rd_prio, rd_state;

    logic              div_start, div_done;
    logic [TOT_W-1:0]  div_rem;

    logic              accept, issue, elig, load_in_range;
    logic [7:0]        weight;
    logic [ACC_W-1:0]  acc_sum;

    logic              draw_result, win_in_range;

    lss_slot_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .clk      (clk),
        .wr       (mem_wr),
        .wr_addr  (mem_wr_addr),
        .rd_addr  (mem_rd_addr),
        .rd_prio  (rd_prio),
        .rd_state (rd_state)
    );

    lss_mod_unit #(
        .DIV_W (TOT_W)
    ) u_mod_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (total_next),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign accept        = start && (state_reg == lss_pkg::S_IDLE);
    assign issue         = (cnt_reg < CNT_W'(NUM_SLOTS));
    assign mem_rd_addr   = cnt_reg[SLOT_W-1:0];
    assign load_in_range = (32'(slot) < NUM_SLOTS);

    // Weight of the slot whose table entry just came back; priority 3 counts as high
    always_comb
    begin
        case (rd_prio)
            lss_pkg::PRIO_LOW:    weight = wl_reg;
            lss_pkg::PRIO_MEDIUM: weight = wm_reg;
            default:              weight = wh_reg;
        endcase
    end

    assign elig    = rv_reg && rpres_reg && (rd_state != lss_pkg::ST_PAUSED);
    assign acc_sum = {1'b0, acc_reg} + ACC_W'(weight);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rv_next        = 1'b0;
        ridx_next      = ridx_reg;
        rpres_next     = rpres_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        win_next       = win_reg;
        pick_next      = pick_reg;
        rnd_next       = rnd_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        present_next   = present_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        chosen_next    = chosen_reg;
        total_out_next = total_out_reg;
        win_out_next   = win_out_reg;
        applied_next   = applied_reg;
        mem_wr         = '0;
        mem_wr_addr    = run_slot_reg;
        div_start      = 1'b0;

        case (state_reg)
            lss_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    status_next    = lss_pkg::STATUS_OK;
                    chosen_next    = '0;
                    total_out_next = '0;
                    win_out_next   = '0;
                    applied_next   = '0;
                    case (operation)
                        lss_pkg::OP_LOAD:
                        begin
                            done_next = 1'b1;
                            if (load_in_range)
                            begin
                                mem_wr.prio_en  = 1'b1;
                                mem_wr.state_en = 1'b1;
                                mem_wr.prio     = priority_req;
                                mem_wr.state    = run_state;
                                mem_wr_addr     = SLOT_W'(slot);
                                present_next[SLOT_W'(slot)] = present;
                                if (!present && run_valid_reg && run_slot_reg == SLOT_W'(slot))
                                begin
                                    run_valid_next = 1'b0;
                                end
                            end
                        end
                        lss_pkg::OP_STATE:
                        begin
                            done_next = 1'b1;
                            if (!run_valid_reg)
                            begin
                                status_next = lss_pkg::STATUS_NO_RUNNING;
                            end
                            else if (run_state == lss_pkg::ST_INVALID)
                            begin
                                status_next = lss_pkg::STATUS_BAD_STATE;
                            end
                            else
                            begin
                                mem_wr.state_en = 1'b1;
                                mem_wr.state    = run_state;
                                applied_next    = run_state;
                            end
                        end
                        lss_pkg::OP_DRAW:
                        begin
                            // Hold the random word for the modulo
                            rnd_next   = random_value;
                            cnt_next   = '0;
                            acc_next   = '0;
                            state_next = lss_pkg::S_SUM;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // Sum eligible weights over the table
            lss_pkg::S_SUM:
            begin
                if (issue)
                begin
                    rv_next    = 1'b1;
                    ridx_next  = cnt_reg[SLOT_W-1:0];
                    rpres_next = present_reg[cnt_reg[SLOT_W-1:0]];
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (elig)
                begin
                    acc_next = acc_sum[TOT_W-1:0];
                end
                if (!issue && !rv_reg)
                begin
                    if (acc_reg == '0)
                    begin
                        status_next = lss_pkg::STATUS_NO_TICKETS;
                        done_next   = 1'b1;
                        state_next  = lss_pkg::S_IDLE;
                    end
                    else
                    begin
                        total_next = acc_reg;
                        div_start  = 1'b1;
                        state_next = lss_pkg::S_MOD;
                    end
                end
            end

            // Wait for the modulo, then restart the walk
            lss_pkg::S_MOD:
            begin
                if (div_done)
                begin
                    win_next   = div_rem;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = lss_pkg::S_SEL;
                end
            end

            // Find the first slot whose running sum passes the winning ticket
            lss_pkg::S_SEL:
            begin
                if (issue)
                begin
                    rv_next    = 1'b1;
                    ridx_next  = cnt_reg[SLOT_W-1:0];
                    rpres_next = present_reg[cnt_reg[SLOT_W-1:0]];
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (elig)
                begin
                    acc_next = acc_sum[TOT_W-1:0];
                    if (acc_sum > {1'b0, win_reg})
                    begin
                        pick_next  = ridx_reg;
                        state_next = lss_pkg::S_UPD_PREV;
                    end
                end
            end

            // Drop the previous runner back to ready
            lss_pkg::S_UPD_PREV:
            begin
                if (run_valid_reg)
                begin
                    mem_wr.state_en = 1'b1;
                    mem_wr.state    = lss_pkg::ST_READY;
                end
                state_next = lss_pkg::S_UPD_PICK;
            end

            // Mark the winner running and report
            lss_pkg::S_UPD_PICK:
            begin
                mem_wr.state_en = 1'b1;
                mem_wr.state    = lss_pkg::ST_RUNNING;
                mem_wr_addr     = pick_reg;
                run_slot_next   = pick_reg;
                run_valid_next  = 1'b1;
                status_next     = lss_pkg::STATUS_OK;
                chosen_next     = 4'(pick_reg);
                total_out_next  = (32'(total_reg) > 32'(lss_pkg::OUT_MAX)) ?
                                  lss_pkg::OUT_MAX : 12'(total_reg);
                win_out_next    = (32'(win_reg) > 32'(lss_pkg::OUT_MAX)) ?
                                  lss_pkg::OUT_MAX : 12'(win_reg);
                done_next       = 1'b1;
                state_next      = lss_pkg::S_IDLE;
            end

            default:
            begin
                state_next = lss_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lss_pkg::S_IDLE;
            cnt_reg       <= '0;
            rv_reg        <= 1'b0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            present_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rv_reg        <= rv_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            present_reg   <= present_next;
            done_reg      <= done_next;
        end
    end

    // Datapath and result registers
    always_ff @(posedge clk)
    begin
        ridx_reg      <= ridx_next;
        rpres_reg     <= rpres_next;
        acc_reg       <= acc_next;
        total_reg     <= total_next;
        win_reg       <= win_next;
        pick_reg      <= pick_next;
        rnd_reg       <= rnd_next;
        status_reg    <= status_next;
        chosen_reg    <= chosen_next;
        total_out_reg <= total_out_next;
        win_out_reg   <= win_out_next;
        applied_reg   <= applied_next;
    end

    // Ticket weights
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= 8'd1;
            wm_reg <= 8'd2;
            wh_reg <= 8'd4;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lss_pkg::CFG_WEIGHT_LOW:    wl_reg <= cfg_data;
                lss_pkg::CFG_WEIGHT_MEDIUM: wm_reg <= cfg_data;
                lss_pkg::CFG_WEIGHT_HIGH:   wh_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign cfg_ready      = 1'b1;
    assign busy           = (state_reg != lss_pkg::S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign chosen_slot    = chosen_reg;
    assign ticket_total   = total_out_reg;
    assign draw_ticket    = win_out_reg;
    assign applied_state  = applied_reg;

    // Checks
    assign draw_result  = done_reg && (total_out_reg != 12'd0);
    assign win_in_range = (win_out_reg < total_out_reg) || (total_out_reg == lss_pkg::OUT_MAX);

    `ASSERT_NEXT(a_accept_progress, clk, rst_n, accept, done_reg || busy)
    `ASSERT_IMPLIES(a_div_in_mod, clk, rst_n, div_done, state_reg == lss_pkg::S_MOD)
    `ASSERT_IMPLIES(a_win_below_total, clk, rst_n, draw_result, win_in_range)
    `ASSERT_IMPLIES(a_draw_sets_runner, clk, rst_n, draw_result, run_valid_reg)

endmodule
